>>> rtl/typedef_lexer_macros.svh
// ----------------------------------------------------------------------------
// Typedef lexer assertion macros
// Shared assertion forms for the lexer checker. Each form samples on the
// rising edge of clock; the reset forms watch the cycle after reset.
// ----------------------------------------------------------------------------
`ifndef TYPEDEF_LEXER_MACROS_SVH
`define TYPEDEF_LEXER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define TLEX_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define TLEX_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define TLEX_CHECK_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tlex_pkg.sv
// ----------------------------------------------------------------------------
// Typedef lexer package
// Transaction types, token kind codes and the keyword tables shared by the
// lexer modules.
// ----------------------------------------------------------------------------
package tlex_pkg;

   // Default sizing of the counters.
   localparam int MAX_WORD_LENGTH_DEF = 255;
   localparam int POSITION_BITS_DEF   = 16;

   // Number of result slots one character can fill.
   localparam int SLOT_COUNT = 4;
   localparam int KW_COUNT   = 7;

   // Token kind codes.
   localparam logic [4:0] KIND_STRUCT   = 5'd0;
   localparam logic [4:0] KIND_ENUM     = 5'd1;
   localparam logic [4:0] KIND_LBRACE   = 5'd2;
   localparam logic [4:0] KIND_RBRACE   = 5'd3;
   localparam logic [4:0] KIND_SEMI     = 5'd4;
   localparam logic [4:0] KIND_COLON    = 5'd5;
   localparam logic [4:0] KIND_LPAREN   = 5'd6;
   localparam logic [4:0] KIND_RPAREN   = 5'd7;
   localparam logic [4:0] KIND_COMMA    = 5'd8;
   localparam logic [4:0] KIND_LANGLE   = 5'd9;
   localparam logic [4:0] KIND_RANGLE   = 5'd10;
   localparam logic [4:0] KIND_OPTIONAL = 5'd11;
   localparam logic [4:0] KIND_LIST     = 5'd12;
   localparam logic [4:0] KIND_STRING   = 5'd13;
   localparam logic [4:0] KIND_INT      = 5'd14;
   localparam logic [4:0] KIND_BOOL     = 5'd15;
   localparam logic [4:0] KIND_IDENT    = 5'd16;
   localparam logic [4:0] KIND_END      = 5'd17;

   // Special characters.
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   // Keyword spelling, length and kind, in candidate-bit order.
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
      '{"e", "n", "u", "m", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "p", "t", "i", "o", "n", "a", "l"},
      '{"l", "i", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd6, 4'd4, 4'd8, 4'd4, 4'd6, 4'd3, 4'd4
   };
   localparam logic [4:0] KW_KIND [KW_COUNT] = '{
      KIND_STRUCT, KIND_ENUM, KIND_OPTIONAL, KIND_LIST,
      KIND_STRING, KIND_INT, KIND_BOOL
   };

   // Input transaction.
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [7:0]  token_length;
      logic        last_of_run;
   } rsp_type;

   // One token before the run marker is known.
   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [7:0]  length;
   } tok_type;

   // All tokens caused by one character, in delivery order.
   typedef struct packed {
      logic [SLOT_COUNT-1:0]            valid;
      tok_type [SLOT_COUNT-1:0]         tok;
   } bundle_type;

endpackage

>>> rtl/typedef_lexer.sv
// ----------------------------------------------------------------------------
// Typedef lexer
// Streaming tokenizer for a small type-definition language: one character
// per input transaction, tokens with kind, position and length out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    char_code, end_of_text
//   rsp_      out         rsp_valid/rsp_ready    token_kind, start_line,
//                                                start_column, token_length,
//                                                last_of_run
//
// A character is taken every cycle while each gives at most one token and
// rsp_ready is high; one that gives n tokens holds the result register until
// all n are taken. Path: the input register, then the token register.
// Synchronous reset clears the counters and the open word, with no sweep.
// A stalled rsp_ side still lets one more character into the input register.
//
module typedef_lexer #(
   parameter int MAX_WORD_LENGTH = tlex_pkg::MAX_WORD_LENGTH_DEF,
   parameter int POSITION_BITS   = tlex_pkg::POSITION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlex_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlex_pkg::rsp_type rsp_data
);

   logic                 in_valid_ff, in_valid_in;
   tlex_pkg::req_type    in_data_ff;
   logic                 fire;
   logic                 load_ok;
   tlex_pkg::bundle_type bundle;

   // Input register handshake.
   always_comb begin
      fire      = in_valid_ff && load_ok;
      req_ready = !in_valid_ff || fire;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Lexer state and token bundle.
   tlex_core #(
      .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
      .POSITION_BITS   (POSITION_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .bundle (bundle)
   );

   // Result register and run serialization.
   tlex_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .bundle    (bundle),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/tlex_core.sv
// ----------------------------------------------------------------------------
// Typedef lexer core
// Holds the position counters and the open-word state, and turns one
// registered character into the bundle of tokens it causes.
// ----------------------------------------------------------------------------
module tlex_core #(
   parameter int MAX_WORD_LENGTH = tlex_pkg::MAX_WORD_LENGTH_DEF,
   parameter int POSITION_BITS   = tlex_pkg::POSITION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  tlex_pkg::req_type    item,
   output tlex_pkg::bundle_type bundle
);

   localparam int LenBits = $clog2(MAX_WORD_LENGTH + 1);
   localparam logic [LenBits-1:0] LenMax = LenBits'(MAX_WORD_LENGTH);

   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] column_ff, column_in;
   logic                     in_word_ff, in_word_in;
   logic [POSITION_BITS-1:0] word_line_ff, word_line_in;
   logic [POSITION_BITS-1:0] word_column_ff, word_column_in;
   logic [LenBits-1:0]       word_len_ff, word_len_in;
   logic [tlex_pkg::KW_COUNT-1:0] cand_ff, cand_in;

   logic [7:0]               c;
   logic                     is_letter, is_digit, is_word_char;
   logic                     punct_hit;
   logic [4:0]               punct_kind;
   logic                     cont, start;
   logic [LenBits-1:0]       base_len, adv_len;
   logic [tlex_pkg::KW_COUNT-1:0] base_cand, adv_cand;
   logic                     open_word;
   logic [POSITION_BITS-1:0] open_line, open_column;
   logic [POSITION_BITS-1:0] line_next, column_next;

   // Kind of a finished word: the first surviving keyword of full length.
   function automatic logic [4:0] word_kind(input logic [tlex_pkg::KW_COUNT-1:0] cand,
                                            input logic [LenBits-1:0] len);
      logic [4:0] kind;
      kind = tlex_pkg::KIND_IDENT;
      for (int k = tlex_pkg::KW_COUNT - 1; k >= 0; k--) begin
         if (cand[k] && len == LenBits'(tlex_pkg::KW_LEN[k])) begin
            kind = tlex_pkg::KW_KIND[k];
         end
      end
      return kind;
   endfunction

   // Reported positions stop at the top of the 16-bit field.
   function automatic logic [15:0] pos_out(input logic [POSITION_BITS-1:0] v);
      logic over;
      over = |(v >> 16);
      return over ? 16'hFFFF : 16'(v);
   endfunction

   // Reported lengths stop at the top of the 8-bit field.
   function automatic logic [7:0] len_out(input logic [LenBits-1:0] v);
      logic over;
      over = |(v >> 8);
      return over ? 8'hFF : 8'(v);
   endfunction

   // Character classes and punctuation lookup.
   always_comb begin
      c          = item.char_code;
      is_letter  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      is_digit   = (c >= "0" && c <= "9");
      is_word_char = is_letter || is_digit || (c == tlex_pkg::CHAR_UNDERSCORE);
      punct_hit  = 1'b1;
      case (c)
         "{":     punct_kind = tlex_pkg::KIND_LBRACE;
         "}":     punct_kind = tlex_pkg::KIND_RBRACE;
         ";":     punct_kind = tlex_pkg::KIND_SEMI;
         ":":     punct_kind = tlex_pkg::KIND_COLON;
         "(":     punct_kind = tlex_pkg::KIND_LPAREN;
         ")":     punct_kind = tlex_pkg::KIND_RPAREN;
         ",":     punct_kind = tlex_pkg::KIND_COMMA;
         "<":     punct_kind = tlex_pkg::KIND_LANGLE;
         ">":     punct_kind = tlex_pkg::KIND_RANGLE;
         default: begin
            punct_kind = tlex_pkg::KIND_IDENT;
            punct_hit  = 1'b0;
         end
      endcase
   end

   // Word tracking: continue the open word or start a new one.
   always_comb begin
      cont      = in_word_ff && is_word_char;
      start     = !cont && (is_letter || c == tlex_pkg::CHAR_UNDERSCORE);
      base_len  = cont ? word_len_ff : '0;
      base_cand = cont ? cand_ff : '1;
      for (int k = 0; k < tlex_pkg::KW_COUNT; k++) begin
         adv_cand[k] = base_cand[k] && (base_len < LenBits'(tlex_pkg::KW_LEN[k]))
                       && (tlex_pkg::KW_TEXT[k][base_len[2:0]] == c);
      end
      adv_len     = (base_len < LenMax) ? base_len + 1'b1 : base_len;
      open_word   = cont || start;
      open_line   = start ? line_ff : word_line_ff;
      open_column = start ? column_ff : word_column_ff;
   end

   // Position counters after this character, saturating.
   always_comb begin
      if (c == tlex_pkg::CHAR_NEWLINE) begin
         line_next   = (&line_ff) ? line_ff : line_ff + 1'b1;
         column_next = '0;
      end else begin
         line_next   = line_ff;
         column_next = (&column_ff) ? column_ff : column_ff + 1'b1;
      end
   end

   // Token bundle: closed word, punctuation, word open at end, end token.
   always_comb begin
      bundle.valid[0]      = in_word_ff && !cont;
      bundle.tok[0].kind   = word_kind(cand_ff, word_len_ff);
      bundle.tok[0].line   = pos_out(word_line_ff);
      bundle.tok[0].column = pos_out(word_column_ff);
      bundle.tok[0].length = len_out(word_len_ff);

      bundle.valid[1]      = punct_hit;
      bundle.tok[1].kind   = punct_kind;
      bundle.tok[1].line   = pos_out(line_ff);
      bundle.tok[1].column = pos_out(column_ff);
      bundle.tok[1].length = 8'd1;

      bundle.valid[2]      = item.end_of_text && open_word;
      bundle.tok[2].kind   = word_kind(adv_cand, adv_len);
      bundle.tok[2].line   = pos_out(open_line);
      bundle.tok[2].column = pos_out(open_column);
      bundle.tok[2].length = len_out(adv_len);

      bundle.valid[3]      = item.end_of_text;
      bundle.tok[3].kind   = tlex_pkg::KIND_END;
      bundle.tok[3].line   = pos_out(line_next);
      bundle.tok[3].column = pos_out(column_next);
      bundle.tok[3].length = 8'd0;
   end

   // Next state; the end of a text returns everything to its reset value.
   always_comb begin
      if (item.end_of_text) begin
         line_in        = '0;
         column_in      = '0;
         in_word_in     = 1'b0;
         word_line_in   = '0;
         word_column_in = '0;
         word_len_in    = '0;
         cand_in        = '1;
      end else begin
         line_in        = line_next;
         column_in      = column_next;
         in_word_in     = open_word;
         word_line_in   = open_line;
         word_column_in = open_column;
         word_len_in    = open_word ? adv_len : '0;
         cand_in        = open_word ? adv_cand : '1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff        <= '0;
         column_ff      <= '0;
         in_word_ff     <= 1'b0;
         word_line_ff   <= '0;
         word_column_ff <= '0;
         word_len_ff    <= '0;
         cand_ff        <= '1;
      end else if (fire) begin
         line_ff        <= line_in;
         column_ff      <= column_in;
         in_word_ff     <= in_word_in;
         word_line_ff   <= word_line_in;
         word_column_ff <= word_column_in;
         word_len_ff    <= word_len_in;
         cand_ff        <= cand_in;
      end
   end

endmodule

>>> rtl/tlex_serializer.sv
// ----------------------------------------------------------------------------
// Typedef lexer result serializer
// Registers the token bundle of one character and hands its tokens out one
// per transaction, marking the final one of the run.
// ----------------------------------------------------------------------------
module tlex_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tlex_pkg::bundle_type bundle,
   output logic                 load_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tlex_pkg::rsp_type    rsp_data
);

   logic [tlex_pkg::SLOT_COUNT-1:0] pending_ff, pending_in;
   tlex_pkg::tok_type               tok_ff [tlex_pkg::SLOT_COUNT];
   logic [tlex_pkg::SLOT_COUNT-1:0] sel_onehot;
   logic [1:0]                      sel;
   logic                            take;
   logic [tlex_pkg::SLOT_COUNT-1:0] remaining;

   // Pick the earliest pending slot.
   always_comb begin
      sel        = 2'd0;
      sel_onehot = '0;
      for (int s = tlex_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
         if (pending_ff[s]) begin
            sel        = 2'(s);
            sel_onehot = tlex_pkg::SLOT_COUNT'(1) << s;
         end
      end
   end

   // Output transaction and what is left after it.
   always_comb begin
      rsp_valid             = |pending_ff;
      take                  = rsp_valid && rsp_ready;
      remaining             = take ? (pending_ff & ~sel_onehot) : pending_ff;
      load_ok               = (remaining == '0);
      pending_in            = load ? bundle.valid : remaining;
      rsp_data.token_kind   = tok_ff[sel].kind;
      rsp_data.start_line   = tok_ff[sel].line;
      rsp_data.start_column = tok_ff[sel].column;
      rsp_data.token_length = tok_ff[sel].length;
      rsp_data.last_of_run  = ((pending_ff & ~sel_onehot) == '0);
   end

   // Pending flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Token payload, captured with each new bundle.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int s = 0; s < tlex_pkg::SLOT_COUNT; s++) begin
            tok_ff[s] <= bundle.tok[s];
         end
      end
   end

endmodule

>>> rtl/tlex_checker.sv
// ----------------------------------------------------------------------------
// Typedef lexer checker
// Port-level assertions on the token stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "typedef_lexer_macros.svh"

module tlex_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tlex_pkg::rsp_type rsp_data
);

   logic rsp_stall;
   logic is_punct;
   logic is_ident;
   logic is_end;
   logic len_zero;
   logic len_one;

   // Token classes seen on the result port while a transaction is offered.
   always_comb begin
      rsp_stall = rsp_valid && !rsp_ready;
      is_punct  = rsp_valid && (rsp_data.token_kind inside
                  {[tlex_pkg::KIND_LBRACE:tlex_pkg::KIND_RANGLE]});
      is_ident  = rsp_valid && (rsp_data.token_kind == tlex_pkg::KIND_IDENT);
      is_end    = rsp_valid && (rsp_data.token_kind == tlex_pkg::KIND_END);
      len_zero  = (rsp_data.token_length == 8'd0);
      len_one   = (rsp_data.token_length == 8'd1);
   end

   // A stalled result transaction holds.
   `TLEX_CHECK_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // The end token is empty and closes its run.
   `TLEX_CHECK(a_end_token, is_end, len_zero && rsp_data.last_of_run, "malformed end token")

   // Punctuation is always one character long.
   `TLEX_CHECK(a_punct_len, is_punct, len_one, "punctuation length is not one")

   // An identifier is never empty.
   `TLEX_CHECK(a_ident_len, is_ident, !len_zero, "empty identifier")

   // Nothing is offered right after reset, and input is open.
   `TLEX_CHECK_RESET(a_reset_idle, reset, !rsp_valid && req_ready, "result port busy after reset")

endmodule

bind typedef_lexer tlex_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
